@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the device sighting table.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dst_pkg.sv @@
// Package of the device sighting table: default sizes, opcodes, result codes
// and the controller state type. No dependencies.
`default_nettype none

package dst_pkg;

    localparam int MAX_DEVICES_DEF = 128;
    localparam int OBSERVERS_PER_DEVICE_DEF = 8;

    localparam int MAC_W = 48;
    localparam int OID_W = 8;
    localparam int RSSI_W = 8;
    localparam int STATUS_W = 3;
    localparam int DEV_SLOT_W = 7;
    localparam int OBS_SLOT_W = 3;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CLEARED     = 3'd0,
        STAT_RSSI_UPDATE = 3'd1,
        STAT_OBS_ADDED   = 3'd2,
        STAT_DEV_ADDED   = 3'd3,
        STAT_TABLE_FULL  = 3'd4,
        STAT_SLOTS_FULL  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DSCAN,
        S_OSCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/dst_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
// No dependencies; used for the device and observer stores.
`default_nettype none

module dst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/device_sighting_table_core.sv @@
// A clear goes straight to its result; a report first scans the D occupied device entries
// and then the O occupied slots of the matched device.
// The core takes one word at a time, held up by the one-entry-per-cycle scans of the
// device RAM and the observer RAM read ports.
// Reset clears the device count and the output valid flag; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module device_sighting_table_core #(
    parameter int MAX_DEVICES = dst_pkg::MAX_DEVICES_DEF,
    parameter int OBSERVERS_PER_DEVICE = dst_pkg::OBSERVERS_PER_DEVICE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_operation,
    input  wire logic [dst_pkg::MAC_W-1:0]     i_mac_address,
    input  wire logic [dst_pkg::OID_W-1:0]     i_observer_id,
    input  wire logic signed [dst_pkg::RSSI_W-1:0] i_signal_strength,
    input  wire logic                          i_victim_flag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [dst_pkg::STATUS_W-1:0]       o_status,
    output logic [dst_pkg::DEV_SLOT_W-1:0]     o_device_slot,
    output logic [dst_pkg::OBS_SLOT_W-1:0]     o_observer_slot,
    output logic                               o_tracking
);

    localparam int DW = $clog2(MAX_DEVICES);
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam int OCW = $clog2(OBSERVERS_PER_DEVICE + 1);
    localparam int SW = (CW > OCW) ? CW : OCW;
    localparam int OBS_DEPTH = MAX_DEVICES * OBSERVERS_PER_DEVICE;
    localparam int AW = $clog2(OBS_DEPTH);
    localparam int DEVW = dst_pkg::MAC_W + OCW + 1;
    localparam int OBSW = dst_pkg::OID_W + dst_pkg::RSSI_W;
    localparam int DSW = dst_pkg::DEV_SLOT_W;
    localparam int OSW = dst_pkg::OBS_SLOT_W;

    dst_pkg::t_state r_state, n_state;

    logic [dst_pkg::MAC_W-1:0]  r_mac;
    logic [dst_pkg::OID_W-1:0]  r_oid;
    logic [dst_pkg::RSSI_W-1:0] r_rssi;
    logic                       r_victim;
    logic [CW-1:0]              r_dev_cnt, n_dev_cnt;
    logic [SW-1:0]              r_ridx, n_ridx;
    logic [SW-1:0]              r_cidx, n_cidx;
    logic [SW-1:0]              r_lim, n_lim;
    logic                       r_cvld, n_cvld;
    logic [DW-1:0]              r_dev_idx, n_dev_idx;
    logic [OCW-1:0]             r_obs_cnt, n_obs_cnt;
    logic                       r_flag, n_flag;
    logic [AW-1:0]              r_base, n_base;

    dst_pkg::t_status           r_res_status, n_res_status;
    logic [DSW-1:0]             r_res_dev, n_res_dev;
    logic [OSW-1:0]             r_res_obs, n_res_obs;
    logic                       r_res_trk, n_res_trk;

    logic                       r_out_vld;
    logic [dst_pkg::STATUS_W-1:0] r_out_status;
    logic [DSW-1:0]             r_out_dev;
    logic [OSW-1:0]             r_out_obs;
    logic                       r_out_trk;

    logic                       dev_we, dev_re, obs_we, obs_re;
    logic [DW-1:0]              dev_waddr, dev_raddr;
    logic [AW-1:0]              obs_waddr, obs_raddr;
    logic [DEVW-1:0]            dev_wdata, dev_q;
    logic [OBSW-1:0]            obs_wdata, obs_q;

    logic                       in_acc, out_free, issue, dev_match, obs_match;
    logic                       st_done, st_scan;
    logic [DW+DSW-1:0]          dev_ext_n, dev_ext_m;
    logic [SW+OSW-1:0]          obs_ext_c;
    logic [OCW+OSW-1:0]         obs_ext_n;

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign issue = r_ridx < r_lim;
    assign dev_match = r_cvld && (dev_q[DEVW-1 -: dst_pkg::MAC_W] == r_mac);
    assign obs_match = r_cvld && (obs_q[OBSW-1 -: dst_pkg::OID_W] == r_oid);
    assign st_done = (r_state == dst_pkg::S_DONE);
    assign st_scan = (r_state == dst_pkg::S_DSCAN) || (r_state == dst_pkg::S_OSCAN);

    assign dev_ext_n = {{DSW{1'b0}}, r_dev_cnt[DW-1:0]};
    assign dev_ext_m = {{DSW{1'b0}}, r_dev_idx};
    assign obs_ext_c = {{OSW{1'b0}}, r_cidx};
    assign obs_ext_n = {{OSW{1'b0}}, r_obs_cnt};

    dst_ram #(
        .WIDTH (DEVW),
        .DEPTH (MAX_DEVICES)
    ) u_dev_ram (
        .i_clk   (i_clk),
        .i_we    (dev_we),
        .i_waddr (dev_waddr),
        .i_wdata (dev_wdata),
        .i_re    (dev_re),
        .i_raddr (dev_raddr),
        .o_rdata (dev_q)
    );

    dst_ram #(
        .WIDTH (OBSW),
        .DEPTH (OBS_DEPTH)
    ) u_obs_ram (
        .i_clk   (i_clk),
        .i_we    (obs_we),
        .i_waddr (obs_waddr),
        .i_wdata (obs_wdata),
        .i_re    (obs_re),
        .i_raddr (obs_raddr),
        .o_rdata (obs_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dst_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_operation == dst_pkg::OP_CLEAR) ? dst_pkg::S_DONE
                                                                 : dst_pkg::S_DSCAN;
                end
            end
            dst_pkg::S_DSCAN: begin
                if (dev_match) begin
                    n_state = dst_pkg::S_OSCAN;
                end else if (!issue) begin
                    n_state = dst_pkg::S_DONE;
                end
            end
            dst_pkg::S_OSCAN: begin
                if (obs_match || !issue) begin
                    n_state = dst_pkg::S_DONE;
                end
            end
            dst_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dst_pkg::S_IDLE;
                end
            end
            default: n_state = dst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_dev_cnt = r_dev_cnt;
        n_ridx = r_ridx;
        n_cidx = r_cidx;
        n_lim = r_lim;
        n_cvld = 1'b0;
        n_dev_idx = r_dev_idx;
        n_obs_cnt = r_obs_cnt;
        n_flag = r_flag;
        n_base = r_base;
        n_res_status = r_res_status;
        n_res_dev = r_res_dev;
        n_res_obs = r_res_obs;
        n_res_trk = r_res_trk;
        dev_we = 1'b0;
        dev_waddr = r_dev_idx;
        dev_wdata = {r_mac, r_obs_cnt, r_flag};
        dev_re = 1'b0;
        dev_raddr = r_ridx[DW-1:0];
        obs_we = 1'b0;
        obs_waddr = r_base;
        obs_wdata = {r_oid, r_rssi};
        obs_re = 1'b0;
        obs_raddr = r_base + AW'(r_ridx);
        unique case (r_state)
            dst_pkg::S_IDLE: begin
                n_ridx = '0;
                n_lim = SW'(r_dev_cnt);
                if (in_acc && (i_operation == dst_pkg::OP_CLEAR)) begin
                    n_dev_cnt = '0;
                    n_res_status = dst_pkg::STAT_CLEARED;
                    n_res_dev = '0;
                    n_res_obs = '0;
                    n_res_trk = 1'b0;
                end
            end
            dst_pkg::S_DSCAN: begin
                if (dev_match) begin
                    n_dev_idx = r_cidx[DW-1:0];
                    n_obs_cnt = dev_q[OCW:1];
                    n_flag = dev_q[0];
                    n_base = AW'(r_cidx[DW-1:0]) * AW'(OBSERVERS_PER_DEVICE);
                    n_ridx = '0;
                    n_lim = SW'(dev_q[OCW:1]);
                end else if (!issue) begin
                    if (r_dev_cnt == CW'(MAX_DEVICES)) begin
                        n_res_status = dst_pkg::STAT_TABLE_FULL;
                        n_res_dev = '0;
                        n_res_obs = '0;
                        n_res_trk = 1'b0;
                    end else begin
                        dev_we = 1'b1;
                        dev_waddr = r_dev_cnt[DW-1:0];
                        dev_wdata = {r_mac, OCW'(1), r_victim};
                        obs_we = 1'b1;
                        obs_waddr = AW'(r_dev_cnt[DW-1:0]) * AW'(OBSERVERS_PER_DEVICE);
                        n_dev_cnt = r_dev_cnt + CW'(1);
                        n_res_status = dst_pkg::STAT_DEV_ADDED;
                        n_res_dev = dev_ext_n[DSW-1:0];
                        n_res_obs = '0;
                        n_res_trk = r_victim;
                    end
                end else begin
                    dev_re = 1'b1;
                    n_ridx = r_ridx + SW'(1);
                    n_cidx = r_ridx;
                    n_cvld = 1'b1;
                end
            end
            dst_pkg::S_OSCAN: begin
                n_res_dev = dev_ext_m[DSW-1:0];
                n_res_trk = r_flag;
                if (obs_match) begin
                    obs_we = 1'b1;
                    obs_waddr = r_base + AW'(r_cidx);
                    n_res_status = dst_pkg::STAT_RSSI_UPDATE;
                    n_res_obs = obs_ext_c[OSW-1:0];
                end else if (!issue) begin
                    if (r_obs_cnt < OCW'(OBSERVERS_PER_DEVICE)) begin
                        obs_we = 1'b1;
                        obs_waddr = r_base + AW'(r_obs_cnt);
                        dev_we = 1'b1;
                        dev_wdata = {r_mac, r_obs_cnt + OCW'(1), r_flag};
                        n_res_status = dst_pkg::STAT_OBS_ADDED;
                        n_res_obs = obs_ext_n[OSW-1:0];
                    end else begin
                        n_res_status = dst_pkg::STAT_SLOTS_FULL;
                        n_res_obs = '0;
                    end
                end else begin
                    obs_re = 1'b1;
                    n_ridx = r_ridx + SW'(1);
                    n_cidx = r_ridx;
                    n_cvld = 1'b1;
                end
            end
            dst_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dst_pkg::S_IDLE;
            r_dev_cnt <= '0;
            r_cvld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dev_cnt <= n_dev_cnt;
            r_cvld <= n_cvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mac <= i_mac_address;
            r_oid <= i_observer_id;
            r_rssi <= i_signal_strength;
            r_victim <= i_victim_flag;
        end
        r_ridx <= n_ridx;
        r_cidx <= n_cidx;
        r_lim <= n_lim;
        r_dev_idx <= n_dev_idx;
        r_obs_cnt <= n_obs_cnt;
        r_flag <= n_flag;
        r_base <= n_base;
        r_res_status <= n_res_status;
        r_res_dev <= n_res_dev;
        r_res_obs <= n_res_obs;
        r_res_trk <= n_res_trk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == dst_pkg::S_DONE) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == dst_pkg::S_DONE) && out_free) begin
            r_out_status <= r_res_status;
            r_out_dev <= r_res_dev;
            r_out_obs <= r_res_obs;
            r_out_trk <= r_res_trk;
        end
    end

    assign o_in_stall = (r_state != dst_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_status = r_out_status;
    assign o_device_slot = r_out_dev;
    assign o_observer_slot = r_out_obs;
    assign o_tracking = r_out_trk;

    `ASSERT_CLK(a_dev_cnt_bound, i_clk, i_rst_n, r_dev_cnt <= CW'(MAX_DEVICES), "count overflow")
    `ASSERT_CLK(a_accept_leaves_idle, i_clk, i_rst_n, in_acc |=> o_in_stall, "word not started")
    `ASSERT_CLK(a_out_done, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(st_done), "stray result")
    `ASSERT_CLK(a_scan_bound, i_clk, i_rst_n, st_scan |-> (r_ridx <= r_lim), "scan overrun")

endmodule

`default_nettype wire
